// ===== rtl/sha1_pkg.sv =====
// ============================================================================
// sha1_pkg
// Shared constants, types and helpers for the streaming SHA-1 engine.
// ============================================================================
package sha1_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int ROUNDS      = 80;
    localparam int BLOCK_WORDS = 16;
    localparam int CHAIN_WORDS = 5;

    localparam logic [7:0] PAD_MARK = 8'h80;

    // initial chaining value, entry 0 is h0
    localparam logic [CHAIN_WORDS-1:0][31:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [31:0] K_ROUND0 = 32'h5A827999;
    localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

    // one 512-bit block handed from the packer to the round unit
    typedef struct packed {
        logic [BLOCK_WORDS-1:0][31:0] words;
        logic                         is_last;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef enum logic [1:0] {
        FR_FILL,
        FR_FULL,
        FR_PAD,
        FR_LEN
    } front_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ROUND,
        BK_ADD,
        BK_OUT
    } back_state_t;

    function automatic logic [31:0] round_k(input logic [6:0] rnd);
        logic [31:0] k;
        priority if (rnd < 7'd20)
        begin
            k = K_ROUND0;
        end
        else if (rnd < 7'd40)
        begin
            k = K_ROUND1;
        end
        else if (rnd < 7'd60)
        begin
            k = K_ROUND2;
        end
        else
        begin
            k = K_ROUND3;
        end
        return k;
    endfunction

endpackage

// ===== rtl/sha1_front.sv =====
// ============================================================================
// sha1_front
// Byte packer: fills a 16-word block big-endian, builds padding and length
// blocks at message end, and hands finished blocks to the queue.
// ============================================================================
module sha1_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 data_valid,
    output logic                 data_stall,
    input  logic [7:0]           data_byte,
    input  logic                 has_byte,
    input  logic                 last,
    input  sha1_pkg::q_status_t  q_stat,
    output logic                 push,
    output sha1_pkg::job_t       push_job
);

    sha1_pkg::front_state_t state_reg;
    sha1_pkg::front_state_t state_next;

    logic [5:0]  slot_reg;
    logic [60:0] msg_reg;
    logic        last_pend_reg;
    logic [3:0][7:0] blk_reg [sha1_pkg::BLOCK_WORDS];

    logic        accept;
    logic        pad_two;
    logic        end_msg;
    logic [63:0] bit_len;
    logic [3:0]  pad_word;
    logic [1:0]  pad_lane;
    logic [31:0] keep_mask;
    logic [31:0] pad_bits;

    assign accept   = data_valid && !data_stall;
    assign pad_two  = (slot_reg[5:3] == 3'b111);
    assign bit_len  = {msg_reg, 3'b000};
    assign pad_word = slot_reg[5:2];
    assign pad_lane = slot_reg[1:0];
    assign end_msg  = push && ((state_reg == sha1_pkg::FR_LEN) ||
                               (state_reg == sha1_pkg::FR_PAD && !pad_two));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sha1_pkg::FR_FILL:
            begin
                if (accept)
                begin
                    if (has_byte && slot_reg == 6'd63)
                    begin
                        state_next = sha1_pkg::FR_FULL;
                    end
                    else if (last)
                    begin
                        state_next = sha1_pkg::FR_PAD;
                    end
                end
            end
            sha1_pkg::FR_FULL:
            begin
                if (push)
                begin
                    state_next = last_pend_reg ? sha1_pkg::FR_PAD : sha1_pkg::FR_FILL;
                end
            end
            sha1_pkg::FR_PAD:
            begin
                if (push)
                begin
                    state_next = pad_two ? sha1_pkg::FR_LEN : sha1_pkg::FR_FILL;
                end
            end
            sha1_pkg::FR_LEN:
            begin
                if (push)
                begin
                    state_next = sha1_pkg::FR_FILL;
                end
            end
            default:
            begin
                state_next = sha1_pkg::FR_FILL;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        data_stall = (state_reg != sha1_pkg::FR_FILL);
        push       = (state_reg != sha1_pkg::FR_FILL) && !q_stat.full;
    end

    // lanes above the pad byte survive, the rest clear
    always_comb
    begin
        unique case (pad_lane)
            2'd0:    keep_mask = 32'h0000_0000;
            2'd1:    keep_mask = 32'hFF00_0000;
            2'd2:    keep_mask = 32'hFFFF_0000;
            default: keep_mask = 32'hFFFF_FF00;
        endcase
        pad_bits = {sha1_pkg::PAD_MARK, 24'h00_0000} >> {pad_lane, 3'b000};
    end

    always_comb
    begin
        for (int i = 0; i < sha1_pkg::BLOCK_WORDS; i++)
        begin
            if (state_reg == sha1_pkg::FR_LEN)
            begin
                push_job.words[i] = 32'h0;
            end
            else if (state_reg == sha1_pkg::FR_PAD)
            begin
                if (4'(i) < pad_word)
                begin
                    push_job.words[i] = blk_reg[i];
                end
                else if (4'(i) == pad_word)
                begin
                    push_job.words[i] = (blk_reg[i] & keep_mask) | pad_bits;
                end
                else
                begin
                    push_job.words[i] = 32'h0;
                end
            end
            else
            begin
                push_job.words[i] = blk_reg[i];
            end
        end
        push_job.is_last = 1'b0;
        if (state_reg == sha1_pkg::FR_LEN || (state_reg == sha1_pkg::FR_PAD && !pad_two))
        begin
            push_job.words[14] = bit_len[63:32];
            push_job.words[15] = bit_len[31:0];
            push_job.is_last   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha1_pkg::FR_FILL;
            slot_reg      <= 6'd0;
            msg_reg       <= 61'd0;
            last_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (end_msg)
            begin
                slot_reg <= 6'd0;
                msg_reg  <= 61'd0;
            end
            else if (accept && has_byte)
            begin
                slot_reg <= slot_reg + 6'd1;
                msg_reg  <= msg_reg + 61'd1;
            end
            if (accept)
            begin
                last_pend_reg <= last;
            end
        end
    end

    // byte lanes, lane 0 starts a fresh word
    always_ff @(posedge clk)
    begin
        if (accept && has_byte)
        begin
            if (slot_reg[1:0] == 2'd0)
            begin
                blk_reg[slot_reg[5:2]] <= {data_byte, 24'h00_0000};
            end
            else
            begin
                blk_reg[slot_reg[5:2]][~slot_reg[1:0]] <= data_byte;
            end
        end
    end

endmodule

// ===== rtl/sha1_queue.sv =====
// ============================================================================
// sha1_queue
// Short block queue between the byte packer and the round unit.
// ============================================================================
module sha1_queue
#(
    parameter int DEPTH = sha1_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sha1_pkg::job_t      push_job,
    input  logic                pop,
    output sha1_pkg::job_t      head_job,
    output sha1_pkg::q_status_t q_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sha1_pkg::job_t slots [DEPTH];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign head_job     = slots[rd_ptr_reg];
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == CW'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + CW'(1);
                2'b01:   count_reg <= count_reg - CW'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("block pushed into full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== rtl/sha1_core.sv =====
// ============================================================================
// sha1_core
// Round unit: one SHA-1 round per cycle over a rolling 16-word schedule,
// chaining update, and the digest output register.
// ============================================================================
module sha1_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  sha1_pkg::q_status_t q_stat,
    input  sha1_pkg::job_t      head_job,
    output logic                pop,
    output logic                digest_valid,
    input  logic                digest_stall,
    output logic [31:0]         digest_word0,
    output logic [31:0]         digest_word1,
    output logic [31:0]         digest_word2,
    output logic [31:0]         digest_word3,
    output logic [31:0]         digest_word4
);

    sha1_pkg::back_state_t state_reg;
    sha1_pkg::back_state_t state_next;

    logic [6:0]  round_reg;
    logic        last_reg;
    logic        out_valid_reg;
    logic [31:0] win_reg    [sha1_pkg::BLOCK_WORDS];
    logic [31:0] vars_reg   [sha1_pkg::CHAIN_WORDS];
    logic [31:0] chain_reg  [sha1_pkg::CHAIN_WORDS];
    logic [31:0] digest_reg [sha1_pkg::CHAIN_WORDS];

    logic        out_load;
    logic [31:0] f_val;
    logic [31:0] w_mix;
    logic [31:0] w_new;
    logic [31:0] t_val;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sha1_pkg::BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = sha1_pkg::BK_ROUND;
                end
            end
            sha1_pkg::BK_ROUND:
            begin
                if (round_reg == 7'(sha1_pkg::ROUNDS - 1))
                begin
                    state_next = sha1_pkg::BK_ADD;
                end
            end
            sha1_pkg::BK_ADD:
            begin
                state_next = last_reg ? sha1_pkg::BK_OUT : sha1_pkg::BK_IDLE;
            end
            sha1_pkg::BK_OUT:
            begin
                if (out_load)
                begin
                    state_next = sha1_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = sha1_pkg::BK_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        pop      = (state_reg == sha1_pkg::BK_IDLE) && !q_stat.empty;
        out_load = (state_reg == sha1_pkg::BK_OUT) && (!out_valid_reg || !digest_stall);
    end

    // round datapath
    always_comb
    begin
        priority if (round_reg < 7'd20)
        begin
            f_val = (vars_reg[1] & vars_reg[2]) | (~vars_reg[1] & vars_reg[3]);
        end
        else if (round_reg < 7'd40)
        begin
            f_val = vars_reg[1] ^ vars_reg[2] ^ vars_reg[3];
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (vars_reg[1] & vars_reg[2]) | (vars_reg[1] & vars_reg[3]) |
                    (vars_reg[2] & vars_reg[3]);
        end
        else
        begin
            f_val = vars_reg[1] ^ vars_reg[2] ^ vars_reg[3];
        end
        w_mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
        w_new = {w_mix[30:0], w_mix[31]};
        t_val = {vars_reg[0][26:0], vars_reg[0][31:27]} + f_val + vars_reg[4] +
                sha1_pkg::round_k(round_reg) + win_reg[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha1_pkg::BK_IDLE;
            round_reg     <= 7'd0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < sha1_pkg::CHAIN_WORDS; j++)
            begin
                chain_reg[j] <= sha1_pkg::H_INIT[j];
            end
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                round_reg <= 7'd0;
                last_reg  <= head_job.is_last;
            end
            else if (state_reg == sha1_pkg::BK_ROUND)
            begin
                round_reg <= round_reg + 7'd1;
            end
            if (state_reg == sha1_pkg::BK_ADD)
            begin
                for (int j = 0; j < sha1_pkg::CHAIN_WORDS; j++)
                begin
                    chain_reg[j] <= chain_reg[j] + vars_reg[j];
                end
            end
            else if (out_load)
            begin
                for (int j = 0; j < sha1_pkg::CHAIN_WORDS; j++)
                begin
                    chain_reg[j] <= sha1_pkg::H_INIT[j];
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !digest_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // schedule window and working variables
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int j = 0; j < sha1_pkg::BLOCK_WORDS; j++)
            begin
                win_reg[j] <= head_job.words[j];
            end
            for (int j = 0; j < sha1_pkg::CHAIN_WORDS; j++)
            begin
                vars_reg[j] <= chain_reg[j];
            end
        end
        else if (state_reg == sha1_pkg::BK_ROUND)
        begin
            for (int j = 0; j < sha1_pkg::BLOCK_WORDS - 1; j++)
            begin
                win_reg[j] <= win_reg[j + 1];
            end
            win_reg[sha1_pkg::BLOCK_WORDS - 1] <= w_new;
            vars_reg[4] <= vars_reg[3];
            vars_reg[3] <= vars_reg[2];
            vars_reg[2] <= {vars_reg[1][1:0], vars_reg[1][31:2]};
            vars_reg[1] <= vars_reg[0];
            vars_reg[0] <= t_val;
        end
        if (out_load)
        begin
            for (int j = 0; j < sha1_pkg::CHAIN_WORDS; j++)
            begin
                digest_reg[j] <= chain_reg[j];
            end
        end
    end

    assign digest_valid = out_valid_reg;
    assign digest_word0 = digest_reg[0];
    assign digest_word1 = digest_reg[1];
    assign digest_word2 = digest_reg[2];
    assign digest_word3 = digest_reg[3];
    assign digest_word4 = digest_reg[4];

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha1_pkg::BK_ROUND) |-> (round_reg < 7'(sha1_pkg::ROUNDS)))
        else $error("round counter out of range");

    a_add_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha1_pkg::BK_ADD) |->
            ($past(state_reg) == sha1_pkg::BK_ROUND &&
             $past(round_reg) == 7'(sha1_pkg::ROUNDS - 1)))
        else $error("chaining add without a full set of rounds");

    a_out_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha1_pkg::BK_OUT) |-> last_reg)
        else $error("digest produced for a block that is not the last");

endmodule

// ===== rtl/sha1_hash_engine.sv =====
// ============================================================================
// sha1_hash_engine
// Streaming SHA-1 over a byte stream, one digest per message.
// ============================================================================
// data channel: one beat per byte (data_byte with has_byte set); the beat
//   with last set ends the message, a beat with only last set hashes the
//   bytes taken so far (none: the empty message), a beat with neither is ignored
// digest channel: one beat per message, digest_word0 most significant
// throughput: the front packs one byte per cycle while data_stall is low and
//   then hands each full 64-byte block to the queue; the round unit takes each
//   block through one load, 80 rounds and one chaining add, while the front
//   packs the next block. data_stall is high while a full, padding or length
//   block is handed to the queue, including any wait for queue space
// message end: digest_valid rises after the chaining add of the padding block
//   when the padding fits one block, or of the length block when the length
//   needs a second block, after any blocks still queued ahead of it
// reset: rst_n loads the initial chaining value and empties the queue
// stall: a stalled digest beat holds; the round unit goes on with the next
//   message and waits only when a second digest is ready
// ============================================================================
module sha1_hash_engine
#(
    parameter int QUEUE_DEPTH = sha1_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last,
    output logic        digest_valid,
    input  logic        digest_stall,
    output logic [31:0] digest_word0,
    output logic [31:0] digest_word1,
    output logic [31:0] digest_word2,
    output logic [31:0] digest_word3,
    output logic [31:0] digest_word4
);

    // blocks moving from the packer to the round unit
    sha1_pkg::job_t      push_job;
    sha1_pkg::job_t      head_job;
    sha1_pkg::q_status_t q_stat;
    logic                push;
    logic                pop;

    // byte packing, padding and length blocks
    sha1_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_stall (data_stall),
        .data_byte  (data_byte),
        .has_byte   (has_byte),
        .last       (last),
        .q_stat     (q_stat),
        .push       (push),
        .push_job   (push_job)
    );

    // decouples packing from compression
    sha1_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    // compression rounds and digest register
    sha1_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .head_job     (head_job),
        .pop          (pop),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_word0 (digest_word0),
        .digest_word1 (digest_word1),
        .digest_word2 (digest_word2),
        .digest_word3 (digest_word3),
        .digest_word4 (digest_word4)
    );

endmodule
